@@ hw/rtl/cfifo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfifo_pkg
// Shared types and constants: field widths, stream packing, opcodes, status
// codes and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cfifo_pkg;

    localparam int OPCODE_W  = 3;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 3;
    localparam int OCC_W     = 5;
    localparam int CAP_W     = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_ENQ        = 3'd0,
        OP_DEQ        = 3'd1,
        OP_PEEK_FRONT = 3'd2,
        OP_PEEK_REAR  = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_READ_POS   = 3'd5,
        OP_CLEAR      = 3'd6,
        OP_NOP        = 3'd7
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_EMPTY     = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_RANGE     = 3'd4
    } status_t;

    typedef struct packed {
        logic accept;
        logic capture;
        logic scan_step;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic go_read;
        logic go_scan;
        logic scan_done;
        logic out_free;
    } dp_stat_t;

endpackage

@@ hw/rtl/cfifo_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfifo_ctrl
// Request sequencer: accepts one request, steps it through the memory read
// or the search scan, then hands the result to the output register.
// ----------------------------------------------------------------------------
module cfifo_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  cfifo_pkg::dp_stat_t stat,
    output logic                s_tready,
    output cfifo_pkg::dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (stat.go_read) begin
                        state_next = ST_READ;
                    end else if (stat.go_scan) begin
                        state_next = ST_SCAN;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_READ: begin
                cmd.capture = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/cfifo_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfifo_dp
// Queue datapath: entry memory, head/tail/count, capacity register, request
// decode, search compare and the output register.
// ----------------------------------------------------------------------------
module cfifo_dp #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  cfifo_pkg::dp_cmd_t                  cmd,
    output cfifo_pkg::dp_stat_t                 stat,
    input  logic                                cfg_wr_en,
    input  logic [cfifo_pkg::CAP_W-1:0]         cfg_wr_data,
    input  logic [cfifo_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [cfifo_pkg::OPCODE_W-1:0]      s_tuser,
    input  logic                                m_tready,
    output logic                                m_tvalid,
    output logic [cfifo_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [cfifo_pkg::STATUS_W-1:0]      m_tuser
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > cfifo_pkg::CAP_W) ? CNT_W : cfifo_pkg::CAP_W;

    localparam logic [CMP_W-1:0]  DEPTH_C   = CMP_W'(DEPTH);
    localparam logic [ADDR_W:0]   DEPTH_A   = (ADDR_W + 1)'(DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] ONE_ADDR  = ADDR_W'(1);
    localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);

    function automatic logic [ADDR_W-1:0] wrap_add(
        input logic [ADDR_W-1:0] base,
        input logic [ADDR_W-1:0] offs
    );
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + {1'b0, offs};
        if (sum >= DEPTH_A) begin
            sum = sum - DEPTH_A;
        end
        return sum[ADDR_W-1:0];
    endfunction

    cfifo_pkg::opcode_t           op;
    logic [cfifo_pkg::DATA_W-1:0] din;
    logic [cfifo_pkg::POS_W-1:0]  pos;
    logic [63:0]                  din_wide;
    logic [WORD_WIDTH-1:0]        key_in;

    logic [WORD_WIDTH-1:0] mem [DEPTH];
    logic [WORD_WIDTH-1:0] rd_word_reg;
    logic [63:0]           rd_wide;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
    logic [ADDR_W-1:0]     acc_addr;

    logic [cfifo_pkg::CAP_W-1:0] cap_reg;
    logic [CMP_W-1:0]            cap_ext;
    logic [CMP_W-1:0]            eff_cap;
    logic [CMP_W-1:0]            cnt_ext;
    logic [CMP_W-1:0]            pos_ext;
    logic                        empty;
    logic                        full;
    logic                        pos_bad;

    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic [WORD_WIDTH-1:0]         key_reg, key_next;
    cfifo_pkg::status_t            res_status_reg, res_status_next;
    cfifo_pkg::status_t            dec_status;
    logic [cfifo_pkg::DATA_W-1:0]  res_data_reg, res_data_next;
    logic [cfifo_pkg::POS_W-1:0]   res_found_reg, res_found_next;
    logic [CNT_W-1:0]              scan_idx_reg, scan_idx_next;
    logic [ADDR_W-1:0]             scan_addr_reg, scan_addr_next;
    logic                          scan_hit;
    logic                          scan_last;
    logic                          go_read;
    logic                          go_scan;

    logic                              m_tvalid_reg, m_tvalid_next;
    logic [cfifo_pkg::M_TDATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic [cfifo_pkg::STATUS_W-1:0]    m_tuser_reg, m_tuser_next;
    logic                              out_free;

    assign op       = cfifo_pkg::opcode_t'(s_tuser);
    assign din      = s_tdata[cfifo_pkg::DATA_W-1:0];
    assign pos      = s_tdata[cfifo_pkg::DATA_W +: cfifo_pkg::POS_W];
    assign din_wide = 64'(din);
    assign key_in   = din_wide[WORD_WIDTH-1:0];
    assign rd_wide  = 64'(rd_word_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= cfifo_pkg::CAP_RESET;
        end else if (cfg_wr_en) begin
            cap_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        cap_ext = CMP_W'(cap_reg);
        if (cap_ext == '0) begin
            eff_cap = CMP_W'(1);
        end else if (cap_ext > DEPTH_C) begin
            eff_cap = DEPTH_C;
        end else begin
            eff_cap = cap_ext;
        end
    end

    assign cnt_ext = CMP_W'(count_reg);
    assign pos_ext = CMP_W'(pos);
    assign empty   = (count_reg == '0);
    assign full    = (cnt_ext >= eff_cap);
    assign pos_bad = (pos_ext >= cnt_ext);

    always_comb begin
        dec_status = cfifo_pkg::STAT_OK;
        go_read    = 1'b0;
        go_scan    = 1'b0;
        acc_addr   = head_reg;
        case (op)
            cfifo_pkg::OP_ENQ: begin
                if (full) begin
                    dec_status = cfifo_pkg::STAT_FULL;
                end
            end
            cfifo_pkg::OP_DEQ, cfifo_pkg::OP_PEEK_FRONT: begin
                if (empty) begin
                    dec_status = cfifo_pkg::STAT_EMPTY;
                end else begin
                    go_read = 1'b1;
                end
            end
            cfifo_pkg::OP_PEEK_REAR: begin
                acc_addr = wrap_add(tail_reg, LAST_ADDR);
                if (empty) begin
                    dec_status = cfifo_pkg::STAT_EMPTY;
                end else begin
                    go_read = 1'b1;
                end
            end
            cfifo_pkg::OP_READ_POS: begin
                acc_addr = wrap_add(head_reg, ADDR_W'(pos));
                if (empty) begin
                    dec_status = cfifo_pkg::STAT_EMPTY;
                end else if (pos_bad) begin
                    dec_status = cfifo_pkg::STAT_RANGE;
                end else begin
                    go_read = 1'b1;
                end
            end
            cfifo_pkg::OP_SEARCH: begin
                if (empty) begin
                    dec_status = cfifo_pkg::STAT_EMPTY;
                end else begin
                    dec_status = cfifo_pkg::STAT_NOT_FOUND;
                    go_scan    = 1'b1;
                end
            end
            default: begin
                dec_status = cfifo_pkg::STAT_OK;
            end
        endcase
    end

    assign scan_hit  = (rd_word_reg == key_reg);
    assign scan_last = (scan_idx_reg == (count_reg - ONE_CNT));
    assign out_free  = !m_tvalid_reg || m_tready;

    always_comb begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_found_next  = res_found_reg;
        scan_idx_next   = scan_idx_reg;
        scan_addr_next  = scan_addr_reg;
        wr_en           = 1'b0;
        wr_addr         = tail_reg;
        rd_en           = 1'b0;
        rd_addr         = acc_addr;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tuser_next    = m_tuser_reg;

        if (cmd.accept) begin
            key_next        = key_in;
            res_status_next = dec_status;
            res_data_next   = '0;
            res_found_next  = '0;
            scan_idx_next   = '0;
            scan_addr_next  = wrap_add(head_reg, ONE_ADDR);
            rd_en           = go_read || go_scan;
            case (op)
                cfifo_pkg::OP_ENQ: begin
                    if (!full) begin
                        wr_en      = 1'b1;
                        tail_next  = wrap_add(tail_reg, ONE_ADDR);
                        count_next = count_reg + ONE_CNT;
                    end
                end
                cfifo_pkg::OP_DEQ: begin
                    if (!empty) begin
                        head_next  = wrap_add(head_reg, ONE_ADDR);
                        count_next = count_reg - ONE_CNT;
                    end
                end
                cfifo_pkg::OP_CLEAR: begin
                    head_next  = '0;
                    tail_next  = '0;
                    count_next = '0;
                end
                default: begin
                    count_next = count_reg;
                end
            endcase
        end

        if (cmd.capture) begin
            res_data_next = rd_wide[cfifo_pkg::DATA_W-1:0];
        end

        if (cmd.scan_step) begin
            if (scan_hit) begin
                res_status_next = cfifo_pkg::STAT_OK;
                res_found_next  = cfifo_pkg::POS_W'(scan_idx_reg);
            end else if (!scan_last) begin
                rd_en          = 1'b1;
                rd_addr        = scan_addr_reg;
                scan_addr_next = wrap_add(scan_addr_reg, ONE_ADDR);
                scan_idx_next  = scan_idx_reg + ONE_CNT;
            end
        end

        if (cmd.emit) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = cfifo_pkg::M_TDATA_W'({cfifo_pkg::OCC_W'(count_reg),
                                                   res_found_reg, res_data_reg});
            m_tuser_next  = res_status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= key_in;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg        <= key_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_found_reg  <= res_found_next;
        scan_idx_reg   <= scan_idx_next;
        scan_addr_reg  <= scan_addr_next;
        m_tdata_reg    <= m_tdata_next;
        m_tuser_reg    <= m_tuser_next;
    end

    assign stat.go_read   = go_read;
    assign stat.go_scan   = go_scan;
    assign stat.scan_done = scan_hit || scan_last;
    assign stat.out_free  = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

@@ hw/rtl/circular_fifo_with_search.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_fifo_with_search
// Circular-buffer queue with enqueue, dequeue, peeks, search, positional read
// and clear; one result transfer per request.
// ----------------------------------------------------------------------------
// The block serves one request at a time and returns exactly one result per
// request. Dequeue, both peeks and read at position pass through a memory
// read state, since the entry memory has one registered read port; enqueue,
// clear, the no-op and every error go straight to the result. Search compares
// one entry per cycle from the front and stops at the first match or at the
// last entry. Write capacity_in_use only while no request is outstanding; 0
// acts as 1 and values above DEPTH act as DEPTH.
module circular_fifo_with_search #(
    parameter int DEPTH      = 16,
    parameter int WORD_WIDTH = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cfifo_pkg::S_TDATA_W-1:0]   s_tdata,   // data_in[31:0], position[35:32]
    input  logic [cfifo_pkg::OPCODE_W-1:0]    s_tuser,   // opcode[2:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cfifo_pkg::M_TDATA_W-1:0]   m_tdata,   // data_out[31:0],
                                                         // found_position[35:32],
                                                         // occupancy[40:36]
    output logic [cfifo_pkg::STATUS_W-1:0]    m_tuser,   // status[2:0]
    input  logic                              cfg_wr_en,
    input  logic [cfifo_pkg::CAP_W-1:0]       cfg_wr_data
);

    cfifo_pkg::dp_cmd_t  cmd;
    cfifo_pkg::dp_stat_t stat;

    cfifo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    cfifo_dp #(
        .DEPTH      (DEPTH),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

`ifndef SYNTHESIS
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in flight");

    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |-> (!m_tvalid || m_tready))
        else $error("result loaded over an untaken result");

    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(cmd.emit))
        else $error("result valid without an emit");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == cfifo_pkg::STAT_EMPTY))
            |-> (m_tdata[cfifo_pkg::DATA_W-1:0] == '0))
        else $error("empty status with nonzero data");
`endif

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for circular_fifo_with_search. Directed requests cover
// the empty queue, word extremes, both peeks, search hit and miss, reads out
// of range, clear and the spare opcode. Random phases under several capacity
// settings follow, with idle bursts on both streams. A queue model predicts
// every result transfer.
// ----------------------------------------------------------------------------
module tb;
    import cfifo_pkg::*;

    localparam int PHASES     = 10;
    localparam int PHASE_REQS = 140;

    typedef struct {
        status_t     status;
        logic [31:0] word;
        logic [3:0]  offset;
        logic [4:0]  occupancy;
    } fifo_result_t;

    class fifo_scoreboard;
        logic [31:0]  slots [16];
        logic [3:0]   head = '0;
        logic [3:0]   tail = '0;
        logic [4:0]   count = '0;
        logic [4:0]   cap_reg = CAP_RESET;
        fifo_result_t expected_q [$];
        int           errors = 0;

        function void set_capacity(logic [4:0] v);
            cap_reg = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_request(opcode_t op, logic [31:0] word, logic [3:0] pos);
            fifo_result_t r;
            logic [4:0]   limit;
            bit           hit;
            limit = (cap_reg == 0) ? 5'd1 : ((cap_reg > 16) ? 5'd16 : cap_reg);
            r.status = STAT_OK;
            r.word   = '0;
            r.offset = '0;
            hit      = 0;
            case (op)
                OP_ENQ: begin
                    if (count >= limit) begin
                        r.status = STAT_FULL;
                    end else begin
                        slots[tail] = word;
                        tail++;
                        count++;
                    end
                end
                OP_DEQ: begin
                    if (count == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        r.word = slots[head];
                        head++;
                        count--;
                    end
                end
                OP_PEEK_FRONT: begin
                    if (count == 0) r.status = STAT_EMPTY;
                    else r.word = slots[head];
                end
                OP_PEEK_REAR: begin
                    if (count == 0) r.status = STAT_EMPTY;
                    else r.word = slots[tail - 4'd1];
                end
                OP_SEARCH: begin
                    if (count == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        r.status = STAT_NOT_FOUND;
                        for (int i = 0; i < count; i++) begin
                            if (!hit && slots[head + 4'(i)] == word) begin
                                hit      = 1;
                                r.status = STAT_OK;
                                r.offset = 4'(i);
                            end
                        end
                    end
                end
                OP_READ_POS: begin
                    if (count == 0) r.status = STAT_EMPTY;
                    else if (5'(pos) >= count) r.status = STAT_RANGE;
                    else r.word = slots[head + pos];
                end
                OP_CLEAR: begin
                    head  = '0;
                    tail  = '0;
                    count = '0;
                end
                default: ;
            endcase
            r.occupancy = count;
            expected_q = {expected_q, r};
        endfunction

        function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [2:0] status, logic [31:0] word, logic [3:0] offset,
                                   logic [4:0] occupancy);
            fifo_result_t r;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result transfer, status %h data %h",
                         $time, status, word);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            compare_field("status", 32'(r.status), 32'(status));
            compare_field("data_out", r.word, word);
            compare_field("found_position", 32'(r.offset), 32'(offset));
            compare_field("occupancy", 32'(r.occupancy), 32'(occupancy));
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OPCODE_W-1:0]  s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CAP_W-1:0]     cfg_wr_data = '0;

    fifo_scoreboard sb = new;
    bit             calm = 0;
    int             stall_left = 0;
    logic [31:0]    key_pool [6];

    circular_fifo_with_search #(
        .DEPTH      (16),
        .WORD_WIDTH (32)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.note_request(opcode_t'(s_tuser), s_tdata[31:0], s_tdata[35:32]);
        end
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tuser, m_tdata[31:0], m_tdata[35:32], m_tdata[40:36]);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || calm) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if ($urandom_range(0, 5) == 0) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 16);
        end
    end

    task automatic send_request(input opcode_t op, input logic [31:0] word,
                                input logic [3:0] pos);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, pos, word};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [4:0] v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        sb.set_capacity(v);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic random_phase(input bit fill_bias);
        int          r;
        opcode_t     op;
        logic [31:0] word;
        logic [3:0]  pos;
        for (int n = 0; n < PHASE_REQS; n++) begin
            r = $urandom_range(0, 99);
            if (r < (fill_bias ? 45 : 25))      op = OP_ENQ;
            else if (r < (fill_bias ? 60 : 50)) op = OP_DEQ;
            else if (r < 65)                    op = OP_PEEK_FRONT;
            else if (r < 70)                    op = OP_PEEK_REAR;
            else if (r < 83)                    op = OP_SEARCH;
            else if (r < 96)                    op = OP_READ_POS;
            else if (r < 97)                    op = OP_CLEAR;
            else                                op = OP_NOP;
            word = $urandom_range(0, 1) ? key_pool[$urandom_range(0, 5)] : $urandom;
            pos  = $urandom_range(0, 1) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
            send_request(op, word, pos);
        end
    endtask

    initial begin
        logic [4:0] cap_plan [PHASES];
        cap_plan = '{5'd31, 5'd0, 5'd1, 5'd16, 5'd5, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0};
        for (int i = 6; i < PHASES; i++) cap_plan[i] = 5'($urandom_range(0, 31));
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 6; i++) key_pool[i] = $urandom;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(OP_DEQ,        32'h0,         4'd0);
        send_request(OP_PEEK_FRONT, 32'h0,         4'd0);
        send_request(OP_PEEK_REAR,  32'h0,         4'd0);
        send_request(OP_SEARCH,     32'h0,         4'd0);
        send_request(OP_READ_POS,   32'h0,         4'd0);
        send_request(OP_ENQ,        32'h0000_0000, 4'd0);
        send_request(OP_ENQ,        32'hFFFF_FFFF, 4'd15);
        send_request(OP_ENQ,        32'hA5A5_5A5A, 4'd0);
        send_request(OP_ENQ,        32'hFFFF_FFFF, 4'd0);
        send_request(OP_PEEK_FRONT, 32'h0,         4'd0);
        send_request(OP_PEEK_REAR,  32'h0,         4'd0);
        send_request(OP_SEARCH,     32'hFFFF_FFFF, 4'd0);
        send_request(OP_SEARCH,     32'h1234_5678, 4'd0);
        send_request(OP_READ_POS,   32'h0,         4'd2);
        send_request(OP_READ_POS,   32'h0,         4'd15);
        send_request(OP_READ_POS,   32'h0,         4'd4);
        send_request(OP_DEQ,        32'h0,         4'd0);
        send_request(OP_NOP,        32'hFFFF_FFFF, 4'd15);
        send_request(OP_CLEAR,      32'h0,         4'd0);
        send_request(OP_DEQ,        32'h0,         4'd0);
        send_request(OP_ENQ,        32'h8000_0001, 4'd0);
        send_request(OP_SEARCH,     32'h8000_0001, 4'd0);

        for (int p = 0; p < PHASES; p++) begin
            write_capacity(cap_plan[p]);
            if (p == PHASES - 1) calm = 1;
            random_phase(p % 2 == 0);
        end

        wait_idle();
        if (sb.errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("%0t: timeout", $time);
        $display("tb: done, errors");
        $finish;
    end

endmodule

@@ circular_fifo_with_search.f @@
hw/rtl/cfifo_pkg.sv
hw/rtl/cfifo_ctrl.sv
hw/rtl/cfifo_dp.sv
hw/rtl/circular_fifo_with_search.sv
tb/tb.sv
